/* src/gmod_pkg.sv */
// Shared types and constants of the graph modularity scorer
package gmod_pkg;

   localparam int ACTION_W    = 2;
   localparam int VERTEX_W    = 10;
   localparam int COMMUNITY_W = 8;
   localparam int NEIGHBOR_W  = 10;
   localparam int SCORE_W     = 31;
   localparam int LINKS_W     = 20;
   localparam int STATUS_W    = 2;
   localparam int FRAC_BITS   = 30;
   localparam int QUOT_W      = FRAC_BITS + 1;
   localparam int DIV_CNT_W   = $clog2(FRAC_BITS);

   typedef logic [ACTION_W-1:0] action_type;
   localparam action_type ACT_ASSIGN = 2'd0;
   localparam action_type ACT_EDGE   = 2'd1;
   localparam action_type ACT_FINISH = 2'd2;

   typedef logic [STATUS_W-1:0] status_type;
   localparam status_type ST_OK       = 2'd0;
   localparam status_type ST_NO_LINKS = 2'd1;
   localparam status_type ST_OVERFLOW = 2'd2;

   localparam logic [QUOT_W-1:0] SCORE_ONE = QUOT_W'(1) << FRAC_BITS;
   localparam logic [QUOT_W-1:0] SCORE_MAX = SCORE_ONE - QUOT_W'(1);

   typedef enum logic [1:0] {
      MUL_ROW = 2'd0,
      MUL_DM  = 2'd1,
      MUL_MM  = 2'd2
   } mul_sel_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic        take;
      logic        clr_wr;
      logic        assign_wr;
      logic        cnt_rd;
      logic        cnt_wr;
      logic        set_ovf;
      logic        walk_rd;
      logic        sum_clr;
      mul_sel_type mul_sel;
      logic        capture_dm;
      logic        sign;
      logic        start_div;
      logic        div_step;
      logic        emit;
      logic        idx_clr;
      logic        idx_inc;
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic       req_valid;
      action_type action;
      logic       assign_ok;
      logic       edge_ok;
      logic       full;
      logic       idx_last_sweep;
      logic       idx_last_walk;
      logic       walk_busy;
      logic       div_last;
      logic       out_free;
   } sts_type;

endpackage

/* src/gmod_if.sv */
// Request and response channel interfaces of the graph modularity scorer
interface gmod_req_if;
   logic                                valid;
   logic                                ready;
   logic [gmod_pkg::ACTION_W-1:0]       action;
   logic [gmod_pkg::VERTEX_W-1:0]       vertex;
   logic [gmod_pkg::COMMUNITY_W-1:0]    community;
   logic [gmod_pkg::NEIGHBOR_W-1:0]     neighbor;

   modport source (output valid, action, vertex, community, neighbor, input ready);
   modport sink   (input valid, action, vertex, community, neighbor, output ready);
endinterface

interface gmod_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [gmod_pkg::SCORE_W-1:0] modularity;
   logic [gmod_pkg::LINKS_W-1:0]        link_count;
   logic [gmod_pkg::STATUS_W-1:0]       status;

   modport source (output valid, modularity, link_count, status, input ready);
   modport sink   (input valid, modularity, link_count, status, output ready);
endinterface

/* src/gmod_ram.sv */
// Generic single write port RAM with one registered read port
module gmod_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and read-first registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/gmod_ctrl.sv */
// Controller state machine of the graph modularity scorer
module gmod_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  gmod_pkg::sts_type sts,
   output gmod_pkg::cmd_type cmd
);

   typedef enum logic [14:0] {
      S_CLEAR    = 15'b000000000000001,
      S_IDLE     = 15'b000000000000010,
      S_DISPATCH = 15'b000000000000100,
      S_ASSIGN   = 15'b000000000001000,
      S_E_MAP    = 15'b000000000010000,
      S_E_CNT    = 15'b000000000100000,
      S_E_WR     = 15'b000000001000000,
      S_SUM      = 15'b000000010000000,
      S_DRAIN    = 15'b000000100000000,
      S_DM       = 15'b000001000000000,
      S_DEN      = 15'b000010000000000,
      S_SIGN     = 15'b000100000000000,
      S_START    = 15'b001000000000000,
      S_DIV      = 15'b010000000000000,
      S_EMIT     = 15'b100000000000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Work out next state and commands
   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      cmd.mul_sel = gmod_pkg::MUL_ROW;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr_wr  = 1'b1;
            cmd.idx_inc = 1'b1;
            if (sts.idx_last_sweep) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            cmd.take = 1'b1;
            if (sts.req_valid) begin
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (sts.action)
               gmod_pkg::ACT_ASSIGN: begin
                  state_in = sts.assign_ok ? S_ASSIGN : S_IDLE;
               end
               gmod_pkg::ACT_EDGE: begin
                  if (!sts.edge_ok) begin
                     state_in = S_IDLE;
                  end else if (sts.full) begin
                     cmd.set_ovf = 1'b1;
                     state_in    = S_IDLE;
                  end else begin
                     state_in = S_E_MAP;
                  end
               end
               gmod_pkg::ACT_FINISH: begin
                  cmd.sum_clr = 1'b1;
                  cmd.idx_clr = 1'b1;
                  state_in    = S_SUM;
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_ASSIGN: begin
            cmd.assign_wr = 1'b1;
            state_in      = S_IDLE;
         end
         S_E_MAP: begin
            state_in = S_E_CNT;
         end
         S_E_CNT: begin
            cmd.cnt_rd = 1'b1;
            state_in   = S_E_WR;
         end
         S_E_WR: begin
            cmd.cnt_wr = 1'b1;
            state_in   = S_IDLE;
         end
         S_SUM: begin
            cmd.walk_rd = 1'b1;
            cmd.idx_inc = 1'b1;
            if (sts.idx_last_walk) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (!sts.walk_busy) begin
               state_in = S_DM;
            end
         end
         S_DM: begin
            cmd.mul_sel = gmod_pkg::MUL_DM;
            state_in    = S_DEN;
         end
         S_DEN: begin
            cmd.mul_sel    = gmod_pkg::MUL_MM;
            cmd.capture_dm = 1'b1;
            state_in       = S_SIGN;
         end
         S_SIGN: begin
            cmd.sign = 1'b1;
            state_in = S_START;
         end
         S_START: begin
            cmd.start_div = 1'b1;
            state_in      = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold state, start with the clearing pass
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* src/gmod_dpath.sv */
// Datapath of the graph modularity scorer: maps, counters, multiplier, divider
module gmod_dpath #(
   parameter int MAX_VERTICES    = 1024,
   parameter int MAX_COMMUNITIES = 256,
   parameter int COUNT_BITS      = 20
) (
   input  logic              clock,
   input  logic              reset,
   input  gmod_pkg::cmd_type cmd,
   output gmod_pkg::sts_type sts,
   gmod_req_if.sink          req_if,
   gmod_rsp_if.source        rsp_if
);

   localparam int VA = $clog2(MAX_VERTICES);
   localparam int CA = (MAX_COMMUNITIES > 1) ? $clog2(MAX_COMMUNITIES) : 1;
   localparam int PW = 2 * COUNT_BITS;
   localparam int SWEEP = (MAX_VERTICES > MAX_COMMUNITIES) ? MAX_VERTICES : MAX_COMMUNITIES;
   localparam int IW = $clog2(SWEEP);
   localparam int QW = gmod_pkg::QUOT_W;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   // Item registers
   gmod_pkg::action_type             action_ff;
   logic [gmod_pkg::VERTEX_W-1:0]    vertex_ff;
   logic [gmod_pkg::COMMUNITY_W-1:0] community_ff;
   logic [gmod_pkg::NEIGHBOR_W-1:0]  neighbor_ff;

   logic [IW-1:0]         idx_ff;
   logic [COUNT_BITS-1:0] total_ff;
   logic                  ovf_ff;
   logic [CA-1:0]         from_ff;
   logic                  same_ff;
   logic                  rd_pend_ff;
   logic                  sq_pend_ff;
   logic [COUNT_BITS-1:0] ins_hold_ff;
   logic [PW-1:0]         prod_ff;
   logic [COUNT_BITS-1:0] d_ff;
   logic [PW-1:0]         s_ff;
   logic [PW-1:0]         dm_ff;
   logic [PW-1:0]         den_ff;
   logic [PW-1:0]         mag_ff;
   logic                  neg_ff;
   logic [PW-1:0]         rem_ff;
   logic [QW-1:0]         quot_ff;
   logic [gmod_pkg::DIV_CNT_W-1:0] div_cnt_ff;
   logic                  rsp_valid_ff;
   logic signed [gmod_pkg::SCORE_W-1:0] score_ff;
   logic [gmod_pkg::LINKS_W-1:0]  links_ff;
   gmod_pkg::status_type  status_ff;

   logic                  take;
   logic                  idx_in_v;
   logic                  idx_in_c;
   logic [CA-1:0]         map_a_data;
   logic [CA-1:0]         map_b_data;
   logic                  map_wr_en;
   logic [VA-1:0]         map_wr_addr;
   logic [CA-1:0]         map_wr_data;
   logic [PW-1:0]         cnt_rd_data;
   logic [COUNT_BITS-1:0] row_data;
   logic [COUNT_BITS-1:0] ins_data;
   logic                  cnt_wr_en;
   logic [CA-1:0]         cnt_wr_addr;
   logic [PW-1:0]         cnt_wr_data;
   logic [CA-1:0]         cnt_rd_addr;
   logic [COUNT_BITS-1:0] mul_a;
   logic [COUNT_BITS-1:0] mul_b;
   logic [PW-1:0]         half_gap;
   logic [QW-1:0]         quot_clamped;
   logic signed [gmod_pkg::SCORE_W-1:0] score_in;

   assign take     = cmd.take && req_if.valid;
   assign idx_in_v = 32'(idx_ff) < MAX_VERTICES;
   assign idx_in_c = 32'(idx_ff) < MAX_COMMUNITIES;

   // Status towards the controller
   assign sts.req_valid      = req_if.valid;
   assign sts.action         = action_ff;
   assign sts.assign_ok      = (32'(vertex_ff) < MAX_VERTICES)
                               && (32'(community_ff) < MAX_COMMUNITIES);
   assign sts.edge_ok        = (32'(vertex_ff) < MAX_VERTICES)
                               && (32'(neighbor_ff) < MAX_VERTICES)
                               && (vertex_ff != neighbor_ff);
   assign sts.full           = total_ff == COUNT_MAX;
   assign sts.idx_last_sweep = idx_ff == IW'(SWEEP - 1);
   assign sts.idx_last_walk  = idx_ff == IW'(MAX_COMMUNITIES - 1);
   assign sts.walk_busy      = rd_pend_ff || sq_pend_ff;
   assign sts.div_last       = div_cnt_ff == gmod_pkg::DIV_CNT_W'(gmod_pkg::FRAC_BITS - 1);
   assign sts.out_free       = !rsp_valid_ff || rsp_if.ready;

   assign req_if.ready = cmd.take;

   // Capture the item on acceptance
   always_ff @(posedge clock) begin
      if (take) begin
         action_ff    <= req_if.action;
         vertex_ff    <= req_if.vertex;
         community_ff <= req_if.community;
         neighbor_ff  <= req_if.neighbor;
      end
   end

   // Vertex to community maps, one copy per read port
   assign map_wr_en   = (cmd.clr_wr && idx_in_v) || cmd.assign_wr;
   assign map_wr_addr = cmd.clr_wr ? idx_ff[VA-1:0] : VA'(vertex_ff);
   assign map_wr_data = cmd.clr_wr ? '0 : CA'(community_ff);

   gmod_ram #(.WIDTH(CA), .DEPTH(MAX_VERTICES)) u_map_src (
      .clock   (clock),
      .wr_en   (map_wr_en),
      .wr_addr (map_wr_addr),
      .wr_data (map_wr_data),
      .rd_addr (VA'(vertex_ff)),
      .rd_data (map_a_data)
   );

   gmod_ram #(.WIDTH(CA), .DEPTH(MAX_VERTICES)) u_map_dst (
      .clock   (clock),
      .wr_en   (map_wr_en),
      .wr_addr (map_wr_addr),
      .wr_data (map_wr_data),
      .rd_addr (VA'(neighbor_ff)),
      .rd_data (map_b_data)
   );

   // Row and inside counters per community, packed in one word
   assign row_data    = cnt_rd_data[PW-1:COUNT_BITS];
   assign ins_data    = cnt_rd_data[COUNT_BITS-1:0];
   assign cnt_wr_en   = (cmd.clr_wr && idx_in_c) || cmd.walk_rd || cmd.cnt_wr;
   assign cnt_wr_addr = cmd.cnt_wr ? from_ff : idx_ff[CA-1:0];
   assign cnt_wr_data = cmd.cnt_wr
                        ? {row_data + COUNT_BITS'(1), ins_data + COUNT_BITS'(same_ff)}
                        : '0;
   assign cnt_rd_addr = cmd.walk_rd ? idx_ff[CA-1:0] : map_a_data;

   gmod_ram #(.WIDTH(PW), .DEPTH(MAX_COMMUNITIES)) u_counts (
      .clock   (clock),
      .wr_en   (cnt_wr_en),
      .wr_addr (cnt_wr_addr),
      .wr_data (cnt_wr_data),
      .rd_addr (cnt_rd_addr),
      .rd_data (cnt_rd_data)
   );

   // Sweep index, link total and overflow flag
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff     <= '0;
         total_ff   <= '0;
         ovf_ff     <= 1'b0;
         rd_pend_ff <= 1'b0;
         sq_pend_ff <= 1'b0;
      end else begin
         if (cmd.idx_clr) begin
            idx_ff <= '0;
         end else if (cmd.idx_inc) begin
            idx_ff <= idx_ff + IW'(1);
         end
         if (cmd.emit) begin
            total_ff <= '0;
            ovf_ff   <= 1'b0;
         end else begin
            if (cmd.cnt_wr) begin
               total_ff <= total_ff + COUNT_BITS'(1);
            end
            if (cmd.set_ovf) begin
               ovf_ff <= 1'b1;
            end
         end
         rd_pend_ff <= cmd.walk_rd;
         sq_pend_ff <= rd_pend_ff;
      end
   end

   // Latch the endpoint communities of an entry
   always_ff @(posedge clock) begin
      if (cmd.cnt_rd) begin
         from_ff <= map_a_data;
         same_ff <= map_a_data == map_b_data;
      end
   end

   // Shared multiplier operands
   always_comb begin
      case (cmd.mul_sel)
         gmod_pkg::MUL_DM: begin
            mul_a = d_ff;
            mul_b = total_ff;
         end
         gmod_pkg::MUL_MM: begin
            mul_a = total_ff;
            mul_b = total_ff;
         end
         default: begin
            mul_a = row_data;
            mul_b = row_data;
         end
      endcase
   end

   // Multiply, accumulate the walk, form the signed numerator
   always_ff @(posedge clock) begin
      prod_ff <= PW'(mul_a) * PW'(mul_b);
      if (rd_pend_ff) begin
         ins_hold_ff <= ins_data;
      end
      if (cmd.sum_clr) begin
         d_ff <= '0;
         s_ff <= '0;
      end else if (sq_pend_ff) begin
         d_ff <= d_ff + ins_hold_ff;
         s_ff <= s_ff + prod_ff;
      end
      if (cmd.capture_dm) begin
         dm_ff <= prod_ff;
      end
      if (cmd.sign) begin
         den_ff <= prod_ff;
         if (dm_ff >= s_ff) begin
            mag_ff <= dm_ff - s_ff;
            neg_ff <= 1'b0;
         end else begin
            mag_ff <= s_ff - dm_ff;
            neg_ff <= 1'b1;
         end
      end
   end

   // Restoring division, one quotient bit per cycle
   assign half_gap = den_ff - rem_ff;

   always_ff @(posedge clock) begin
      if (cmd.start_div) begin
         div_cnt_ff <= '0;
         if (mag_ff >= den_ff) begin
            quot_ff <= QW'(1);
            rem_ff  <= '0;
         end else begin
            quot_ff <= '0;
            rem_ff  <= mag_ff;
         end
      end else if (cmd.div_step) begin
         div_cnt_ff <= div_cnt_ff + gmod_pkg::DIV_CNT_W'(1);
         if (rem_ff >= half_gap) begin
            rem_ff  <= rem_ff - half_gap;
            quot_ff <= {quot_ff[QW-2:0], 1'b1};
         end else begin
            rem_ff  <= {rem_ff[PW-2:0], 1'b0};
            quot_ff <= {quot_ff[QW-2:0], 1'b0};
         end
      end
   end

   // Clamp and apply the sign
   always_comb begin
      if (neg_ff) begin
         quot_clamped = (quot_ff > gmod_pkg::SCORE_ONE) ? gmod_pkg::SCORE_ONE : quot_ff;
         score_in     = -$signed(quot_clamped);
      end else begin
         quot_clamped = (quot_ff > gmod_pkg::SCORE_MAX) ? gmod_pkg::SCORE_MAX : quot_ff;
         score_in     = $signed(quot_clamped);
      end
   end

   // Output register, hold until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         links_ff <= gmod_pkg::LINKS_W'(total_ff);
         if (total_ff == '0) begin
            score_ff  <= '0;
            status_ff <= gmod_pkg::ST_NO_LINKS;
         end else begin
            score_ff  <= score_in;
            status_ff <= ovf_ff ? gmod_pkg::ST_OVERFLOW : gmod_pkg::ST_OK;
         end
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.modularity = score_ff;
   assign rsp_if.link_count = links_ff;
   assign rsp_if.status     = status_ff;

`ifndef SYNTHESIS
   a_link_step: assert property (@(posedge clock) disable iff (reset)
      cmd.cnt_wr && !cmd.emit |=> total_ff == $past(total_ff) + COUNT_BITS'(1))
      else $error("link total did not advance by one");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step && den_ff != '0 |-> rem_ff < den_ff)
      else $error("division remainder out of range");

   a_emit_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_valid_ff && total_ff == '0 && !ovf_ff)
      else $error("emit did not load result and clear counters");
`endif

endmodule

/* src/graph_modularity_scorer.sv */
// Top level of the graph modularity scorer
// Scores a community partition by Newman modularity, q = (D*m - sum r_i^2) / m^2, given in
// Q1.30 and truncated toward zero. Items are taken one at a time. After reset a clearing
// pass over max(MAX_VERTICES, MAX_COMMUNITIES) entries zeroes the maps and counters, and
// no item is taken meanwhile. An adjacency entry passes through the registered reads of
// the community maps and the read-modify-write of the counter memory; a dropped item goes
// straight back to waiting. A finish item reads one counter word per cycle on the community
// walk, then uses a shared multiplier and a divider giving one quotient bit per cycle, and
// may wait for the output register to free. The result waits in an output register.
module graph_modularity_scorer #(
   parameter int MAX_VERTICES    = 1024,
   parameter int MAX_COMMUNITIES = 256,
   parameter int COUNT_BITS      = 20
) (
   input logic        clock,
   input logic        reset,
   gmod_req_if.sink   req_if,
   gmod_rsp_if.source rsp_if
);

   gmod_pkg::cmd_type cmd;
   gmod_pkg::sts_type sts;

   gmod_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .cmd   (cmd)
   );

   gmod_dpath #(
      .MAX_VERTICES    (MAX_VERTICES),
      .MAX_COMMUNITIES (MAX_COMMUNITIES),
      .COUNT_BITS      (COUNT_BITS)
   ) u_dpath (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .sts    (sts),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

endmodule
